[src/telemetry_frame_builder_core_assert.svh]
// Assertion macros used by the frame builder core RTL.
`ifndef TELEMETRY_FRAME_BUILDER_CORE_ASSERT_SVH
`define TELEMETRY_FRAME_BUILDER_CORE_ASSERT_SVH

// Same-cycle implication under synchronous active-low reset.
`define TFB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under synchronous active-low reset.
`define TFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/tfb_pkg.sv]
`timescale 1ns / 1ps

package tfb_pkg;

    localparam int FRAME_LEN   = 10;
    localparam int SUM_BYTES   = 8;

    localparam logic [7:0] HDR_BYTE    = 8'hAA;
    localparam logic [7:0] ADDR_BYTE   = 8'hFF;
    localparam logic [7:0] PAYLOAD_LEN = 8'd4;

    typedef logic [7:0] t_byte;
    typedef logic [15:0] t_word;
    typedef t_byte [FRAME_LEN-1:0] t_frame;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    function automatic t_frame build_frame(input t_byte id, input t_word v1, input t_word v2);
        t_frame f;
        t_byte  sa;
        t_byte  sb;
        f[0] = HDR_BYTE;
        f[1] = ADDR_BYTE;
        f[2] = id;
        f[3] = PAYLOAD_LEN;
        f[4] = v1[7:0];
        f[5] = v1[15:8];
        f[6] = v2[7:0];
        f[7] = v2[15:8];
        sa = '0;
        sb = '0;
        for (int i = 0; i < SUM_BYTES; i++) begin
            sa = sa + f[i];
            sb = sb + sa;
        end
        f[8] = sa;
        f[9] = sb;
        return f;
    endfunction

endpackage

[src/tfb_in_if.sv]
`timescale 1ns / 1ps

interface tfb_in_if import tfb_pkg::*; ();
    logic         valid;
    logic         ready;
    t_byte        frame_id;
    logic signed [15:0] first_value;
    logic signed [15:0] second_value;

    modport source (output valid, output frame_id, output first_value, output second_value,
                    input ready);
    modport sink   (input valid, input frame_id, input first_value, input second_value,
                    output ready);
endinterface

[src/tfb_out_if.sv]
`timescale 1ns / 1ps

interface tfb_out_if import tfb_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

[src/telemetry_frame_builder_core.sv]
// Telemetry frame builder.
// i_in (valid/ready) takes one transaction: frame_id, first_value, second_value.
// o_out (valid/ready) returns ten byte transactions per input: 0xAA, 0xFF, frame_id,
// length 4, first_value low/high, second_value low/high, check byte A, check byte B.
// last_byte is high on check byte B only.
// An accepted input enters a holding register, where both check bytes are formed, and
// then loads a row of ten byte cells in parallel; the row shifts toward o_out one
// byte per accepted output transaction.
// With the row empty, the frame goes from the holding register into the cells, and cell 0 drives o_out.
// Bytes leave one per cycle while o_out.ready is high, set by the ten-cell row
// draining through the single byte output; the next frame loads in the cycle its
// predecessor's last byte leaves, so bytes flow without gaps.
// When o_out.ready is low the row holds; the holding register still takes one more
// input, after which i_in.ready drops until the row drains.
// Reset (synchronous, active low) empties the holding register and all cells.
`timescale 1ns / 1ps
`include "telemetry_frame_builder_core_assert.svh"

module telemetry_frame_builder_core import tfb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tfb_in_if.sink    i_in,
    tfb_out_if.source o_out
);

    logic           r_hold_valid;
    t_frame         r_frame;
    t_cell_ctl      w_ctl;
    logic           w_load;
    logic           w_accept;
    t_byte          w_byte  [FRAME_LEN];
    logic [FRAME_LEN-1:0] w_last;
    logic [FRAME_LEN-1:0] w_valid;

    assign w_ctl.shift = !w_valid[0] || o_out.ready;
    assign w_load      = r_hold_valid && !(|w_valid[FRAME_LEN-1:1]) && w_ctl.shift;
    assign w_ctl.load  = w_load;
    assign i_in.ready  = !r_hold_valid || w_load;
    assign w_accept    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
        end else if (w_accept) begin
            r_hold_valid <= 1'b1;
        end else if (w_load) begin
            r_hold_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_frame <= build_frame(i_in.frame_id, t_word'(i_in.first_value),
                                   t_word'(i_in.second_value));
        end
    end

    genvar k;
    generate
        for (k = 0; k < FRAME_LEN; k++) begin : g_cell
            t_byte w_nbyte;
            logic  w_nlast;
            logic  w_nvalid;
            if (k == FRAME_LEN - 1) begin : g_end
                assign w_nbyte  = '0;
                assign w_nlast  = 1'b0;
                assign w_nvalid = 1'b0;
            end else begin : g_mid
                assign w_nbyte  = w_byte[k+1];
                assign w_nlast  = w_last[k+1];
                assign w_nvalid = w_valid[k+1];
            end
            tfb_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_load_byte  (r_frame[k]),
                .i_load_last  (k == FRAME_LEN - 1),
                .i_next_byte  (w_nbyte),
                .i_next_last  (w_nlast),
                .i_next_valid (w_nvalid),
                .o_byte       (w_byte[k]),
                .o_last       (w_last[k]),
                .o_valid      (w_valid[k])
            );
        end
    endgenerate

    assign o_out.valid     = w_valid[0];
    assign o_out.out_byte  = w_byte[0];
    assign o_out.last_byte = w_last[0];

    `TFB_ASSERT_NEXT(a_load_fills_row, i_clk, i_rst_n, w_load,
        w_valid[FRAME_LEN-1] && w_last[FRAME_LEN-1] && !(|w_last[FRAME_LEN-2:0]),
        "row load did not place the closing byte at the far cell")
    `TFB_ASSERT_NOW(a_last_ends_row, i_clk, i_rst_n, o_out.valid && o_out.last_byte,
        !(|w_valid[FRAME_LEN-1:1]), "closing byte sent while later cells still hold data")
    `TFB_ASSERT_NOW(a_hold_free_ready, i_clk, i_rst_n, !r_hold_valid, i_in.ready,
        "input stalled with an empty holding register")

endmodule

[src/tfb_cell.sv]
`timescale 1ns / 1ps

module tfb_cell import tfb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_byte     i_load_byte,
    input  logic      i_load_last,
    input  t_byte     i_next_byte,
    input  logic      i_next_last,
    input  logic      i_next_valid,
    output t_byte     o_byte,
    output logic      o_last,
    output logic      o_valid
);

    logic  r_valid;
    t_byte r_byte;
    logic  r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= 1'b1;
        end else if (i_ctl.shift) begin
            r_valid <= i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_byte <= i_load_byte;
            r_last <= i_load_last;
        end else if (i_ctl.shift) begin
            r_byte <= i_next_byte;
            r_last <= i_next_last;
        end
    end

    assign o_byte  = r_byte;
    assign o_last  = r_last;
    assign o_valid = r_valid;

endmodule

[tb/tfb_frame_checker.sv]
`timescale 1ns / 1ps

module tfb_frame_checker import tfb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    tfb_in_if    i_in,
    tfb_out_if   i_out,
    output int   o_mismatches,
    output int   o_bytes_owed
);

    typedef struct packed {
        t_byte value;
        logic  last;
    } t_frame_byte;

    t_frame_byte owed_bytes_q[$];
    int          frame_pos;

    function automatic void append_frame_bytes(input t_byte id, input t_word first,
                                               input t_word second);
        t_byte body [SUM_BYTES];
        t_byte run_a;
        t_byte run_b;
        body  = '{HDR_BYTE, ADDR_BYTE, id, PAYLOAD_LEN,
                  first[7:0], first[15:8], second[7:0], second[15:8]};
        run_a = '0;
        run_b = '0;
        foreach (body[k]) begin
            run_a = run_a + body[k];
            run_b = run_b + run_a;
            owed_bytes_q.push_back('{body[k], 1'b0});
        end
        owed_bytes_q.push_back('{run_a, 1'b0});
        owed_bytes_q.push_back('{run_b, 1'b1});
    endfunction

    initial begin
        o_mismatches = 0;
        o_bytes_owed = 0;
        frame_pos    = 0;
    end

    always @(posedge i_clk) begin
        t_frame_byte want;
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready) begin
                append_frame_bytes(i_in.frame_id, i_in.first_value, i_in.second_value);
            end
            if (i_out.valid && i_out.ready) begin
                if (owed_bytes_q.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: unexpected byte transaction: expected none, got %02h last %0b",
                             $time, i_out.out_byte, i_out.last_byte);
                end else begin
                    want = owed_bytes_q.pop_front();
                    if (i_out.out_byte !== want.value) begin
                        o_mismatches++;
                        $display("%0t: frame byte %0d: expected %02h, got %02h",
                                 $time, frame_pos, want.value, i_out.out_byte);
                    end
                    if (i_out.last_byte !== want.last) begin
                        o_mismatches++;
                        $display("%0t: frame byte %0d last flag: expected %0b, got %0b",
                                 $time, frame_pos, want.last, i_out.last_byte);
                    end
                    frame_pos = want.last ? 0 : frame_pos + 1;
                end
            end
            o_bytes_owed = owed_bytes_q.size();
        end
    end

endmodule

[tb/telemetry_frame_builder_core_tb.sv]
`timescale 1ns / 1ps

module telemetry_frame_builder_core_tb;
    import tfb_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   bytes_owed;
    int   send_idle_pct;
    int   recv_idle_pct;

    tfb_in_if  in_ch ();
    tfb_out_if out_ch ();

    telemetry_frame_builder_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    tfb_frame_checker u_frame_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_mismatches (mismatches),
        .o_bytes_owed (bytes_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("telemetry_frame_builder_core test failed");
        $finish;
    end

    task automatic send_frame(input t_byte id, input t_word first, input t_word second);
        int  gap;
        logic taken;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.frame_id     <= id;
        in_ch.first_value  <= first;
        in_ch.second_value <= second;
        do begin
            @(negedge i_clk);
            taken = in_ch.ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    function automatic t_word pick_word();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return t_word'($urandom_range(16'hFFFF));
        endcase
    endfunction

    task automatic send_random_frames(input int count);
        for (int n = 0; n < count; n++) begin
            send_frame(t_byte'($urandom_range(255)), pick_word(), pick_word());
        end
    endtask

    // Receiver: random idling, plus one long hold-off once neither side idles.
    initial begin
        int   hold_left;
        logic pressure_done;
        hold_left     = 0;
        pressure_done = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (!pressure_done && i_rst_n && send_idle_pct == 0
                         && recv_idle_pct == 0) begin
                hold_left     = 300;
                pressure_done = 1'b1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        send_idle_pct = 16;
        recv_idle_pct = 82;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.frame_id     <= '0;
        in_ch.first_value  <= '0;
        in_ch.second_value <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_frame(8'h00, 16'h0000, 16'h0000);
        send_frame(8'hFF, 16'hFFFF, 16'hFFFF);
        send_frame(8'h01, 16'h7FFF, 16'h8000);
        send_frame(8'h80, 16'h8000, 16'h7FFF);
        send_frame(8'hAA, 16'h5555, 16'hAAAA);
        send_frame(8'h55, 16'hAAAA, 16'h5555);
        send_frame(8'h7F, 16'h0001, 16'hFFFE);
        send_frame(8'hFE, 16'h00FF, 16'hFF00);
        send_frame(8'h04, 16'h0100, 16'h00FF);
        send_frame(8'hF0, 16'hFF01, 16'h8001);
        send_frame(8'h0F, 16'hC000, 16'h3FFF);
        send_frame(8'hFF, 16'h8000, 16'h8000);
        send_frame(8'h00, 16'h7FFF, 16'h7FFF);
        send_frame(8'h3C, 16'hFFFF, 16'h0000);

        send_random_frames(115);
        send_idle_pct = 82;
        recv_idle_pct = 16;
        send_random_frames(115);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_frames(115);
        in_ch.valid <= 1'b0;

        @(negedge i_clk);
        wait (bytes_owed == 0);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("telemetry_frame_builder_core test passed");
        end else begin
            $display("telemetry_frame_builder_core test failed");
        end
        $finish;
    end

endmodule
